### rtl/gray4_framebuffer_scanout_macros.svh
// assertion macros used by the rtl file gfs_ctrl.sv
`ifndef GRAY4_FRAMEBUFFER_SCANOUT_MACROS_SVH
`define GRAY4_FRAMEBUFFER_SCANOUT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gray4 framebuffer assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gray4 framebuffer assertion failed");

`endif

### rtl/gfs_pkg.sv
// shared types and constants of the grayscale framebuffer scanout
`default_nettype none
package gfs_pkg;

  localparam int PANEL_WIDTH_DEF  = 304;
  localparam int PANEL_HEIGHT_DEF = 96;

  localparam int CMD_BYTES = 4;
  localparam int ROW_W     = 7;

  // input beat operation codes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // positions of the command bytes inside a row
  localparam int POS_PAGE   = 0;
  localparam int POS_ROW    = 1;
  localparam int POS_COL_HI = 2;
  localparam int POS_COL_LO = 3;

  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [3:0] GRAY_MAX    = 4'hF;
  localparam logic [7:0] OFFSET_RST  = 8'd20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_EM_RD,
    ST_EM_LOAD
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic wr_rd;
    logic wr_wb;
    logic em_rd;
    logic em_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/gfs_ram.sv
// generic single-clock ram with registered read
`default_nettype none
module gfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/gfs_ctrl.sv
// sequencing state machine: clearing pass, pixel read-modify-write, stream byte
`default_nettype none
`include "gray4_framebuffer_scanout_macros.svh"
module gfs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_op,
  output logic                 in_ready,
  input  wire gfs_pkg::status_t sts,
  output gfs_pkg::cmd_t        cmd
);

  gfs_pkg::state_t state_r, state_nxt;
  logic            refresh_op;

  assign refresh_op = (in_op == gfs_pkg::OP_REFRESH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gfs_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = gfs_pkg::ST_IDLE;
      end
      gfs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = refresh_op ? gfs_pkg::ST_EM_RD : gfs_pkg::ST_WR_RD;
      end
      gfs_pkg::ST_WR_RD:   state_nxt = gfs_pkg::ST_WR_WB;
      gfs_pkg::ST_WR_WB:   state_nxt = gfs_pkg::ST_IDLE;
      gfs_pkg::ST_EM_RD:   state_nxt = gfs_pkg::ST_EM_LOAD;
      gfs_pkg::ST_EM_LOAD: begin
        if (sts.out_free) state_nxt = gfs_pkg::ST_IDLE;
      end
      default:             state_nxt = gfs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      gfs_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
      gfs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      gfs_pkg::ST_WR_RD:   cmd.wr_rd = 1'b1;
      gfs_pkg::ST_WR_WB:   cmd.wr_wb = 1'b1;
      gfs_pkg::ST_EM_RD:   cmd.em_rd = 1'b1;
      gfs_pkg::ST_EM_LOAD: cmd.em_load = sts.out_free;
      default:             cmd = '0;
    endcase
  end

  `ASSERT_IMPL(a_no_accept_in_clear, state_r == gfs_pkg::ST_CLEAR, !in_ready)
  `ASSERT_IMPL(a_load_needs_room, cmd.em_load, sts.out_free)
  `ASSERT_NEXT(a_emit_reads_next, in_valid && in_ready && refresh_op, state_r == gfs_pkg::ST_EM_RD)
  `ASSERT_NEXT(a_wb_follows_read, state_r == gfs_pkg::ST_WR_RD, cmd.wr_wb)

endmodule
`default_nettype wire

### rtl/gfs_datapath.sv
// address generation, nibble merge, scan counters and output register
`default_nettype none
module gfs_datapath #(
  parameter int PANEL_WIDTH  = gfs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = gfs_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gfs_pkg::cmd_t    cmd,
  output gfs_pkg::status_t      sts,
  input  wire logic             cfg_valid,
  input  wire logic [7:0]       cfg_data,
  input  wire logic [8:0]       in_pixel_x,
  input  wire logic [6:0]       in_pixel_y,
  input  wire logic [7:0]       in_gray_level,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       out_byte,
  output logic                  out_is_data,
  output logic                  out_frame_end
);

  localparam int ROW_BYTES = (PANEL_WIDTH + 1) / 2;
  localparam int STORE     = ROW_BYTES * PANEL_HEIGHT;
  localparam int AW        = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int POS_W     = $clog2(ROW_BYTES + gfs_pkg::CMD_BYTES);
  localparam int RW        = gfs_pkg::ROW_W;

  logic [AW-1:0]    clr_cnt_r;
  logic [7:0]       offset_r;
  logic [AW-1:0]    addr_r;
  logic             odd_r;
  logic             ok_r;
  logic [3:0]       gray_r;
  logic [POS_W-1:0] pos_r;
  logic [RW-1:0]    row_r;
  logic [AW-1:0]    row_base_r;
  logic             out_valid_r;
  logic [7:0]       byte_r;
  logic             data_r;
  logic             last_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic [AW-1:0]    emit_addr;
  logic [7:0]       merged;
  logic [7:0]       byte_nxt;
  logic             data_nxt;
  logic             row_end;
  logic             last_row;

  gfs_ram #(.WIDTH(8), .DEPTH(STORE)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.clr_done = (clr_cnt_r == AW'(STORE - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // row base plus data position minus the four command bytes, modulo the address width
  assign emit_addr = row_base_r + AW'(pos_r) - AW'(gfs_pkg::CMD_BYTES);
  assign merged    = odd_r ? {ram_rdata[7:4], gray_r} : {gray_r, ram_rdata[3:0]};

  assign ram_we    = cmd.clr_step || (cmd.wr_wb && ok_r);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clr_step ? 8'h00 : merged;
  assign ram_re    = cmd.wr_rd || cmd.em_rd;
  assign ram_raddr = cmd.em_rd ? emit_addr : addr_r;

  assign row_end  = (pos_r == POS_W'(ROW_BYTES + gfs_pkg::CMD_BYTES - 1));
  assign last_row = (row_r == RW'(PANEL_HEIGHT - 1));

  always_comb begin
    byte_nxt = ram_rdata;
    data_nxt = 1'b0;
    case (pos_r)
      POS_W'(gfs_pkg::POS_PAGE):   byte_nxt = gfs_pkg::CMD_PAGE;
      POS_W'(gfs_pkg::POS_ROW):    byte_nxt = {1'b0, row_r};
      POS_W'(gfs_pkg::POS_COL_HI): byte_nxt = gfs_pkg::CMD_COL_HI | {4'h0, offset_r[7:4]};
      POS_W'(gfs_pkg::POS_COL_LO): byte_nxt = {4'h0, offset_r[3:0]};
      default: begin
        byte_nxt = ram_rdata;
        data_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      offset_r    <= gfs_pkg::OFFSET_RST;
      pos_r       <= '0;
      row_r       <= '0;
      row_base_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step && !sts.clr_done) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_valid) offset_r <= cfg_data;
      if (cmd.em_load) begin
        out_valid_r <= 1'b1;
        if (row_end) begin
          pos_r <= '0;
          if (last_row) begin
            row_r      <= '0;
            row_base_r <= '0;
          end else begin
            row_r      <= row_r + RW'(1);
            row_base_r <= row_base_r + AW'(ROW_BYTES);
          end
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured pixel beat, dropped later if off the panel, and the loaded output byte
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= AW'(in_pixel_y) * AW'(ROW_BYTES) + AW'(in_pixel_x[8:1]);
      odd_r  <= in_pixel_x[0];
      ok_r   <= ({1'b0, in_pixel_x} < 10'(PANEL_WIDTH)) &&
                ({1'b0, in_pixel_y} < 8'(PANEL_HEIGHT));
      gray_r <= (|in_gray_level[7:4]) ? gfs_pkg::GRAY_MAX : in_gray_level[3:0];
    end
    if (cmd.em_load) begin
      byte_r <= byte_nxt;
      data_r <= data_nxt;
      last_r <= data_nxt && row_end && last_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_is_data   = data_r;
  assign out_frame_end = last_r;

endmodule
`default_nettype wire

### rtl/gray4_framebuffer_scanout.sv
// top level of the 4-bit grayscale framebuffer with refresh byte stream
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | in_op, in_pixel_x, in_pixel_y, in_gray_level
//  out     | out_valid / out_ready | out_byte, out_is_data, out_frame_end
//  cfg     | cfg_valid / cfg_ready | cfg_data (column offset)
//
// every input beat passes through three steps: accept, ram read, then write-back or
// output load, all through the one port pair of the frame store
// a stream byte waits in its load state while out_valid is high and out_ready low
// after reset a clearing pass zeroes the store, one byte a cycle, ROW_BYTES *
// PANEL_HEIGHT bytes (14592 at the defaults); in_ready stays low meanwhile
// cfg writes are taken in any cycle
`default_nettype none
module gray4_framebuffer_scanout #(
  parameter int PANEL_WIDTH  = gfs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = gfs_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_op,
  input  wire logic [8:0] in_pixel_x,
  input  wire logic [6:0] in_pixel_y,
  input  wire logic [7:0] in_gray_level,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_byte,
  output logic            out_is_data,
  output logic            out_frame_end,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  gfs_pkg::cmd_t    cmd;
  gfs_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  gfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gfs_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_gray_level (in_gray_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_is_data   (out_is_data),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire
